[design/sfls_pkg.sv]
// Shared types, constants and the step program for the state-feedback loop core.
// Depends on nothing; every other design file uses it.
`default_nettype none

package sfls_pkg;

    localparam int SIG_W    = 32;   // Q16.16 signal width
    localparam int COEF_W   = 32;   // Q4.28 coefficient width
    localparam int COEF_FRAC = 28;
    localparam int PROD_W   = SIG_W + COEF_W;
    localparam int RND_W    = PROD_W - COEF_FRAC;  // rounded product width
    localparam int ACC_W    = 40;   // room for four rounded terms and a signal
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 32;

    // Sample period 0.1 in Q4.28
    localparam logic signed [COEF_W-1:0] PERIOD_COEF = 32'sd26843546;

    localparam logic signed [COEF_W-1:0] RST_GAIN_ONE = 32'sd563714;
    localparam logic signed [COEF_W-1:0] RST_GAIN_TWO = 32'sd107374;
    localparam logic signed [COEF_W-1:0] RST_LAG      = 32'sd53687091;
    localparam logic signed [COEF_W-1:0] RST_LEAD     = 32'sd53687091;
    localparam logic signed [COEF_W-1:0] RST_SELF     = -32'sd17257716;
    localparam logic signed [COEF_W-1:0] RST_CROSS    = -32'sd1916629;
    localparam logic signed [COEF_W-1:0] RST_OUT_ONE  = 32'sd95858301;
    localparam logic signed [COEF_W-1:0] RST_OUT_TWO  = 32'sd19166292;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_STATE_ONE,
        CFG_GAIN_STATE_TWO,
        CFG_ACTUATOR_LAG,
        CFG_ACTUATOR_LEAD,
        CFG_PLANT_SELF,
        CFG_PLANT_CROSS,
        CFG_OUTPUT_ONE,
        CFG_OUTPUT_TWO
    } cfg_idx_t;

    typedef enum logic [3:0] {
        SIG_ZERO,
        SIG_REF,
        SIG_X1,
        SIG_X2,
        SIG_PREV,
        SIG_CMDP,
        SIG_CMD,
        SIG_X1N,
        SIG_X2N,
        SIG_DLAG,
        SIG_DLEAD
    } sig_sel_t;

    typedef enum logic [3:0] {
        COEF_K1,
        COEF_K2,
        COEF_LAG,
        COEF_LEAD,
        COEF_SELF,
        COEF_CROSS,
        COEF_OUT1,
        COEF_OUT2,
        COEF_DT
    } coef_sel_t;

    typedef enum logic {
        BASE_ACC,
        BASE_SIG
    } base_t;

    typedef enum logic [1:0] {
        TERM_NONE,
        TERM_ADD_PROD,
        TERM_SUB_PROD,
        TERM_SUB_SIG
    } term_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_CMD,
        DST_X1N,
        DST_X2N,
        DST_DLAG,
        DST_DLEAD,
        DST_Y
    } dst_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_FINISH
    } jump_t;

    // One control word: multiplier operands, accumulator update, write-back, sequencing.
    typedef struct packed {
        sig_sel_t  mul_a;
        coef_sel_t mul_b;
        base_t     base;
        sig_sel_t  base_sel;
        term_t     term;
        sig_sel_t  sub_sel;
        dst_t      dst;
        jump_t     jump;
    } ucode_t;

    typedef struct packed {
        logic signed [SIG_W-1:0] plant_output;
        logic signed [SIG_W-1:0] command;
        logic signed [SIG_W-1:0] actuator_output;
    } result_t;

    localparam int PROG_LEN = 14;
    localparam int STEP_W   = $clog2(PROG_LEN);

    // The accumulator consumes, at each step, the product issued one step earlier.
    localparam ucode_t UCODE [PROG_LEN] = '{
        '{SIG_X1,   COEF_K1,    BASE_ACC, SIG_ZERO, TERM_NONE,     SIG_ZERO, DST_NONE,  JMP_WAIT_IN},
        '{SIG_X2,   COEF_K2,    BASE_SIG, SIG_REF,  TERM_SUB_PROD, SIG_ZERO, DST_NONE,  JMP_NEXT},
        '{SIG_X1,   COEF_SELF,  BASE_ACC, SIG_ZERO, TERM_SUB_PROD, SIG_ZERO, DST_NONE,  JMP_NEXT},
        '{SIG_X2,   COEF_CROSS, BASE_SIG, SIG_X1,   TERM_ADD_PROD, SIG_ZERO, DST_CMD,   JMP_NEXT},
        '{SIG_PREV, COEF_DT,    BASE_ACC, SIG_ZERO, TERM_ADD_PROD, SIG_ZERO, DST_NONE,  JMP_NEXT},
        '{SIG_X1,   COEF_DT,    BASE_ACC, SIG_ZERO, TERM_ADD_PROD, SIG_ZERO, DST_NONE,  JMP_NEXT},
        '{SIG_ZERO, COEF_K1,    BASE_SIG, SIG_X2,   TERM_ADD_PROD, SIG_ZERO, DST_X1N,   JMP_NEXT},
        '{SIG_ZERO, COEF_K1,    BASE_SIG, SIG_CMD,  TERM_SUB_SIG,  SIG_PREV, DST_X2N,   JMP_NEXT},
        '{SIG_X1N,  COEF_OUT1,  BASE_SIG, SIG_CMD,  TERM_SUB_SIG,  SIG_CMDP, DST_DLAG,  JMP_NEXT},
        '{SIG_X2N,  COEF_OUT2,  BASE_SIG, SIG_ZERO, TERM_ADD_PROD, SIG_ZERO, DST_DLEAD, JMP_NEXT},
        '{SIG_DLAG, COEF_LAG,   BASE_ACC, SIG_ZERO, TERM_ADD_PROD, SIG_ZERO, DST_NONE,  JMP_NEXT},
        '{SIG_DLEAD, COEF_LEAD, BASE_SIG, SIG_PREV, TERM_ADD_PROD, SIG_ZERO, DST_Y,     JMP_NEXT},
        '{SIG_ZERO, COEF_K1,    BASE_ACC, SIG_ZERO, TERM_ADD_PROD, SIG_ZERO, DST_NONE,  JMP_NEXT},
        '{SIG_ZERO, COEF_K1,    BASE_ACC, SIG_ZERO, TERM_NONE,     SIG_ZERO, DST_NONE,  JMP_FINISH}
    };

    function automatic logic signed [SIG_W-1:0] sat_sig(input logic signed [ACC_W-1:0] v);
        logic all_ones;
        logic all_zeros;
        all_ones  = &v[ACC_W-1:SIG_W-1];
        all_zeros = ~|v[ACC_W-1:SIG_W-1];
        if (all_ones || all_zeros)
            sat_sig = v[SIG_W-1:0];
        else if (v[ACC_W-1])
            sat_sig = {1'b1, {(SIG_W-1){1'b0}}};
        else
            sat_sig = {1'b0, {(SIG_W-1){1'b1}}};
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_sig(input logic signed [SIG_W-1:0] s);
        ext_sig = {{(ACC_W-SIG_W){s[SIG_W-1]}}, s};
    endfunction

endpackage

`default_nettype wire

[design/sfls_if.sv]
// Handshake channels of the loop core: sample words in, result words out.
// Depends on sfls_pkg for the signal width.
`default_nettype none

interface sfls_in_if;
    logic                            valid;
    logic                            ready;
    logic signed [sfls_pkg::SIG_W-1:0] reference;

    modport source (output valid, output reference, input ready);
    modport sink   (input valid, input reference, output ready);
endinterface

interface sfls_out_if;
    logic                            valid;
    logic                            ready;
    logic signed [sfls_pkg::SIG_W-1:0] plant_output;
    logic signed [sfls_pkg::SIG_W-1:0] command;
    logic signed [sfls_pkg::SIG_W-1:0] actuator_output;

    modport source (output valid, output plant_output, output command,
                    output actuator_output, input ready);
    modport sink   (input valid, input plant_output, input command,
                    input actuator_output, output ready);
endinterface

`default_nettype wire

[design/sfls_datapath.sv]
// Datapath of the loop core: coefficient registers, loop state, scratch registers,
// one shared multiplier and a saturating accumulator. Depends on sfls_pkg.
`default_nettype none

module sfls_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sfls_pkg::ucode_t                  ctl,
    input  wire logic                              ref_load,
    input  wire logic signed [sfls_pkg::SIG_W-1:0] ref_data,
    input  wire logic                              commit,
    input  wire logic                              cfg_we,
    input  wire logic [sfls_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sfls_pkg::CFG_W-1:0]        cfg_data,
    output sfls_pkg::result_t                      result
);
    import sfls_pkg::*;

    logic signed [COEF_W-1:0] k1_reg, k2_reg, lag_reg, lead_reg;
    logic signed [COEF_W-1:0] self_reg, cross_reg, out1_reg, out2_reg;

    logic signed [SIG_W-1:0] x1_reg, x2_reg, prev_reg, cmdp_reg;
    logic signed [SIG_W-1:0] ref_reg, cmd_reg, x1n_reg, x2n_reg;
    logic signed [SIG_W-1:0] dlag_reg, dlead_reg, y_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    logic signed [SIG_W-1:0]  mul_a, base_sig, sub_sig, acc_sat;
    logic signed [COEF_W-1:0] mul_b;
    logic signed [ACC_W-1:0]  prod_rnd, base_val;

    function automatic logic signed [SIG_W-1:0] pick_sig(input sig_sel_t sel);
        case (sel)
            SIG_REF:   pick_sig = ref_reg;
            SIG_X1:    pick_sig = x1_reg;
            SIG_X2:    pick_sig = x2_reg;
            SIG_PREV:  pick_sig = prev_reg;
            SIG_CMDP:  pick_sig = cmdp_reg;
            SIG_CMD:   pick_sig = cmd_reg;
            SIG_X1N:   pick_sig = x1n_reg;
            SIG_X2N:   pick_sig = x2n_reg;
            SIG_DLAG:  pick_sig = dlag_reg;
            SIG_DLEAD: pick_sig = dlead_reg;
            default:   pick_sig = '0;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg    <= RST_GAIN_ONE;
            k2_reg    <= RST_GAIN_TWO;
            lag_reg   <= RST_LAG;
            lead_reg  <= RST_LEAD;
            self_reg  <= RST_SELF;
            cross_reg <= RST_CROSS;
            out1_reg  <= RST_OUT_ONE;
            out2_reg  <= RST_OUT_TWO;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_STATE_ONE: k1_reg    <= cfg_data;
                CFG_GAIN_STATE_TWO: k2_reg    <= cfg_data;
                CFG_ACTUATOR_LAG:   lag_reg   <= cfg_data;
                CFG_ACTUATOR_LEAD:  lead_reg  <= cfg_data;
                CFG_PLANT_SELF:     self_reg  <= cfg_data;
                CFG_PLANT_CROSS:    cross_reg <= cfg_data;
                CFG_OUTPUT_ONE:     out1_reg  <= cfg_data;
                CFG_OUTPUT_TWO:     out2_reg  <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        mul_a    = pick_sig(ctl.mul_a);
        base_sig = pick_sig(ctl.base_sel);
        sub_sig  = pick_sig(ctl.sub_sel);
        case (ctl.mul_b)
            COEF_K1:    mul_b = k1_reg;
            COEF_K2:    mul_b = k2_reg;
            COEF_LAG:   mul_b = lag_reg;
            COEF_LEAD:  mul_b = lead_reg;
            COEF_SELF:  mul_b = self_reg;
            COEF_CROSS: mul_b = cross_reg;
            COEF_OUT1:  mul_b = out1_reg;
            COEF_OUT2:  mul_b = out2_reg;
            COEF_DT:    mul_b = PERIOD_COEF;
            default:    mul_b = '0;
        endcase
    end

    // Round half up to Q16.16: the bit just below the cut is the carry in.
    assign prod_rnd = {{(ACC_W-RND_W){prod_reg[PROD_W-1]}}, prod_reg[PROD_W-1:COEF_FRAC]}
                    + {{(ACC_W-1){1'b0}}, prod_reg[COEF_FRAC-1]};

    assign acc_sat = sat_sig(acc_reg);

    always_comb
    begin
        base_val = (ctl.base == BASE_SIG) ? ext_sig(base_sig) : acc_reg;
        case (ctl.term)
            TERM_ADD_PROD: acc_next = base_val + prod_rnd;
            TERM_SUB_PROD: acc_next = base_val - prod_rnd;
            TERM_SUB_SIG:  acc_next = base_val - ext_sig(sub_sig);
            default:       acc_next = base_val;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (ref_load)
            ref_reg <= ref_data;
        case (ctl.dst)
            DST_CMD:   cmd_reg   <= acc_sat;
            DST_X1N:   x1n_reg   <= acc_sat;
            DST_X2N:   x2n_reg   <= acc_sat;
            DST_DLAG:  dlag_reg  <= acc_sat;
            DST_DLEAD: dlead_reg <= acc_sat;
            DST_Y:     y_reg     <= acc_sat;
            default:   ;
        endcase
    end

    // Loop state: advance only when the tick is handed to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg   <= '0;
            x2_reg   <= '0;
            prev_reg <= '0;
            cmdp_reg <= '0;
        end
        else if (commit)
        begin
            x1_reg   <= x1n_reg;
            x2_reg   <= x2n_reg;
            prev_reg <= acc_sat;
            cmdp_reg <= cmd_reg;
        end
    end

    assign result.plant_output    = y_reg;
    assign result.command         = cmd_reg;
    assign result.actuator_output = acc_sat;

endmodule

`default_nettype wire

[design/state_feedback_loop_step_core.sv]
// Top level of the state-feedback loop core: step sequencer and output register.
// A new sample word is taken only after the step program has finished the previous
// tick, driving the single shared multiplier through ten products and the accumulator
// through its sums, and has handed that tick's result to the result register.
// Reset: rst_n clears the loop state to zero, restores the coefficient defaults and
// leaves the result register empty; the core is ready for a sample straight away.
`default_nettype none

module state_feedback_loop_step_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sfls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sfls_pkg::CFG_W-1:0]     cfg_data,
    sfls_in_if.sink                             samples,
    sfls_out_if.source                          results
);
    import sfls_pkg::*;

    // Sequencer: the step counter addresses the control store; each word either
    // advances, waits for a sample, or waits for room in the result register.
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            ctl;
    logic              in_accept;
    logic              commit;

    logic              out_valid_reg, out_valid_next;
    result_t           out_word_reg;
    result_t           dp_result;

    assign ctl = UCODE[step_reg];

    // Take a sample only on the wait step; the result register is independent,
    // so a sample may enter while the previous word is still waiting downstream.
    assign samples.ready = (ctl.jump == JMP_WAIT_IN);
    assign in_accept     = samples.valid && samples.ready;

    // Finish the tick once the result register is empty or being drained.
    assign commit = (ctl.jump == JMP_FINISH) && (!out_valid_reg || results.ready);

    always_comb
    begin
        case (ctl.jump)
            JMP_WAIT_IN: step_next = in_accept ? step_reg + 1'b1 : step_reg;
            JMP_FINISH:  step_next = commit ? '0 : step_reg;
            default:     step_next = step_reg + 1'b1;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result word until the sink takes it.
    always_ff @(posedge clk)
    begin
        if (commit)
            out_word_reg <= dp_result;
    end

    sfls_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .ref_load  (in_accept),
        .ref_data  (samples.reference),
        .commit    (commit),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (dp_result)
    );

    assign results.valid           = out_valid_reg;
    assign results.plant_output    = out_word_reg.plant_output;
    assign results.command         = out_word_reg.command;
    assign results.actuator_output = out_word_reg.actuator_output;

    // Never overwrite a result word that the sink has not taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (!results.valid || results.ready))
        else $error("result word overwritten before it was taken");

    // The result register only fills at the end of a tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> $past(commit))
        else $error("result word raised without a finished tick");

    // Once a sample is taken, the core is busy on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !samples.ready)
        else $error("sample accepted while a tick was in progress");

endmodule

`default_nettype wire
